// ===== sv/modexp_pkg.sv =====
// Package for the 64-bit modular exponentiation block.
// Holds the operand widths and the sequencer state type.
// No dependencies.
package modexp_pkg;

  localparam int OP_W  = 64;               // signed operand width
  localparam int RES_W = OP_W - 1;         // residue width, modulus below 2^63
  localparam int CNT_W = $clog2(OP_W);     // bit counter of the serial unit

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FIX,
    ST_CHECK,
    ST_MULRES,
    ST_SQUARE,
    ST_OUTPUT
  } state_t;

endpackage

// ===== sv/modular_exponentiation_64.sv =====
// Top level: base^exponent mod modulus on signed 64-bit operands.
// Right-to-left square-and-multiply on one bit-serial modular multiplier.
// Depends on modexp_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  input   | in_valid  | in_stall  | base_value, exponent, modulus
//  output  | out_valid | out_stall | power_result, bad_modulus
//
// Steps: reduce the base, fold a negative base, then per exponent bit up to
// its highest set bit a check, a multiply (set bits only) and a square,
// then a last check and the output state, which offers the result beat.
// A bad modulus goes straight from idle to the output state.
// Synchronous active-high reset returns to idle. in_stall is high from the
// accepted beat until the result beat is taken; out_stall holds the result.
module modular_exponentiation_64 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [modexp_pkg::OP_W-1:0]  base_value,
  input  logic signed [modexp_pkg::OP_W-1:0]  exponent,
  input  logic signed [modexp_pkg::OP_W-1:0]  modulus,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic        [modexp_pkg::RES_W-1:0] power_result,
  output logic                           bad_modulus
);

  localparam int OP_W  = modexp_pkg::OP_W;
  localparam int RES_W = modexp_pkg::RES_W;
  localparam int CNT_W = modexp_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OP_W - 1);

  modexp_pkg::state_t state, state_next;

  // Operand and working registers
  logic [RES_W-1:0] mod_r;      // positive modulus
  logic [RES_W-1:0] expo;       // remaining exponent bits, 0 if exponent <= 0
  logic [RES_W-1:0] cur;        // running square
  logic [RES_W-1:0] res;        // running product
  logic             base_neg;
  logic             bad;
  logic [RES_W-1:0] acc;        // serial multiplier accumulator
  logic [OP_W-1:0]  mb;         // multiplier bits, consumed MSB first
  logic [CNT_W-1:0] cnt;

  // Sequencer outputs
  logic in_acc;
  logic out_acc;
  logic sel_res;                // addend is res rather than cur / one

  // Serial unit signals
  logic [RES_W-1:0] addend;
  logic [OP_W-1:0]  dbl;
  logic [OP_W-1:0]  dbl_red;
  logic [OP_W-1:0]  sum;
  logic [OP_W-1:0]  sum_red;
  logic [RES_W-1:0] acc_step;
  logic             last_bit;

  logic [OP_W-1:0]  mag;
  logic             mod_bad_in;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign last_bit = (cnt == CNT_LAST);

  // Input decode: bad modulus and base magnitude
  assign mod_bad_in = modulus[OP_W-1] || (modulus == '0);
  assign mag = base_value[OP_W-1] ? (~base_value + OP_W'(1)) : base_value;

  // Serial modular multiply step: acc = 2*acc (+ addend) mod m
  always_comb begin
    if (state == modexp_pkg::ST_REDUCE) begin
      addend = RES_W'(1);
    end else if (sel_res) begin
      addend = res;
    end else begin
      addend = cur;
    end
    dbl      = {acc, 1'b0};
    dbl_red  = (dbl >= {1'b0, mod_r}) ? dbl - {1'b0, mod_r} : dbl;
    sum      = {1'b0, dbl_red[RES_W-1:0]} + {1'b0, addend};
    sum_red  = (sum >= {1'b0, mod_r}) ? sum - {1'b0, mod_r} : sum;
    acc_step = mb[OP_W-1] ? sum_red[RES_W-1:0] : dbl_red[RES_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = mod_bad_in ? modexp_pkg::ST_OUTPUT : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (last_bit) state_next = modexp_pkg::ST_FIX;
      end
      modexp_pkg::ST_FIX: state_next = modexp_pkg::ST_CHECK;
      modexp_pkg::ST_CHECK: begin
        if (expo == '0) begin
          state_next = modexp_pkg::ST_OUTPUT;
        end else if (expo[0]) begin
          state_next = modexp_pkg::ST_MULRES;
        end else begin
          state_next = modexp_pkg::ST_SQUARE;
        end
      end
      modexp_pkg::ST_MULRES: begin
        if (last_bit) state_next = modexp_pkg::ST_SQUARE;
      end
      modexp_pkg::ST_SQUARE: begin
        if (last_bit) state_next = modexp_pkg::ST_CHECK;
      end
      modexp_pkg::ST_OUTPUT: begin
        if (out_acc) state_next = modexp_pkg::ST_IDLE;
      end
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    sel_res   = 1'b0;
    case (state)
      modexp_pkg::ST_IDLE:   in_stall = 1'b0;
      modexp_pkg::ST_MULRES: sel_res = 1'b1;
      modexp_pkg::ST_OUTPUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_acc) begin
          mod_r    <= modulus[RES_W-1:0];
          expo     <= exponent[OP_W-1] ? '0 : exponent[RES_W-1:0];
          base_neg <= base_value[OP_W-1];
          bad      <= mod_bad_in;
          res      <= '0;
          acc      <= '0;
          mb       <= mag;
          cnt      <= '0;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        acc <= acc_step;
        mb  <= {mb[OP_W-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
      end
      modexp_pkg::ST_FIX: begin
        // fold a negative base into 0..m-1; seed product with 1 mod m
        cur <= (base_neg && acc != '0) ? mod_r - acc : acc;
        res <= (mod_r == RES_W'(1)) ? '0 : RES_W'(1);
      end
      modexp_pkg::ST_CHECK: begin
        acc <= '0;
        mb  <= {1'b0, cur};
        cnt <= '0;
      end
      modexp_pkg::ST_MULRES: begin
        cnt <= cnt + CNT_W'(1);
        if (last_bit) begin
          res <= acc_step;
          acc <= '0;
          mb  <= {1'b0, cur};
        end else begin
          acc <= acc_step;
          mb  <= {mb[OP_W-2:0], 1'b0};
        end
      end
      modexp_pkg::ST_SQUARE: begin
        cnt <= cnt + CNT_W'(1);
        acc <= acc_step;
        mb  <= {mb[OP_W-2:0], 1'b0};
        if (last_bit) begin
          cur  <= acc_step;
          expo <= {1'b0, expo[RES_W-1:1]};
        end
      end
      default: ;
    endcase
  end

  assign power_result = res;
  assign bad_modulus  = bad;

endmodule

// ===== sv/modexp_checker.sv =====
// Port-level checker for modular_exponentiation_64, with its bind.
// Sees only the top-level ports. Depends on modexp_pkg for widths.
module modexp_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [modexp_pkg::RES_W-1:0]    power_result,
  input logic                            bad_modulus
);

  // an error beat carries a zero result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_modulus |-> power_result == '0)
    else $error("bad modulus beat with nonzero result");

  // one item in flight: no input beat while a result is offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // after an input beat the block is busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accepted beat");

  // exactly one result per item: valid drops after the result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

endmodule

bind modular_exponentiation_64 modexp_port_checks u_modexp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .power_result (power_result),
  .bad_modulus  (bad_modulus)
);
